// ===== rtl/lj_pkg.sv =====
// ----------------------------------------------------------------------------
// lj_pkg
// shared types and constants of the lennard-jones energy accumulator
// ----------------------------------------------------------------------------
package lj_pkg;

   localparam int FRAC_BITS   = 16;
   localparam int CFG_W       = 31;
   localparam int POS_W       = 32;
   localparam int SUM_W       = 48;
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_AW    = 1;

   localparam logic [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
   localparam logic [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

   localparam logic [2:0] CSR_WELL_DEPTH    = 3'd0;
   localparam logic [2:0] CSR_CONTACT_SIZE  = 3'd1;
   localparam logic [2:0] CSR_CUTOFF_RADIUS = 3'd2;
   localparam logic [2:0] CSR_BOX_WIDTH_X   = 3'd3;
   localparam logic [2:0] CSR_BOX_WIDTH_Y   = 3'd4;
   localparam logic [2:0] CSR_BOX_WIDTH_Z   = 3'd5;
   localparam logic [2:0] CSR_PERIODIC_MASK = 3'd6;

   typedef struct packed {
      logic [CFG_W-1:0] well_depth;
      logic [CFG_W-1:0] contact_size;
      logic [CFG_W-1:0] cutoff_radius;
      logic [CFG_W-1:0] box_width_x;
      logic [CFG_W-1:0] box_width_y;
      logic [CFG_W-1:0] box_width_z;
      logic [2:0]       periodic_mask;
   } lj_cfg_type;

   typedef struct packed {
      logic        term_en;
      logic [63:0] r2;
      logic        last;
   } lj_job_type;

   typedef enum logic [1:0] {F_IDLE, F_DIV, F_SQ, F_PUSH} front_state_type;

   typedef enum logic [2:0] {
      B_IDLE, B_SIG, B_DIV, B_DEND, B_MUL, B_EVAL, B_ACC
   } back_state_type;

   typedef enum logic [1:0] {OP_Q4, OP_S6, OP_S12, OP_TERM} mul_op_type;

endpackage

// ===== rtl/lj_front.sv =====
// ----------------------------------------------------------------------------
// lj_front
// takes a pair, wraps the separation to the nearest image on periodic axes,
// squares it and classifies the pair against the cutoff
// ----------------------------------------------------------------------------
module lj_front (
   input  logic                     clock,
   input  logic                     reset,
   input  lj_pkg::lj_cfg_type       cfg,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic signed [31:0]       req_ref_x,
   input  logic signed [31:0]       req_ref_y,
   input  logic signed [31:0]       req_ref_z,
   input  logic signed [31:0]       req_neighbor_x,
   input  logic signed [31:0]       req_neighbor_y,
   input  logic signed [31:0]       req_neighbor_z,
   input  logic                     req_is_self,
   input  logic                     req_last_neighbor,
   output lj_pkg::lj_job_type       job,
   output logic                     job_valid,
   input  logic                     job_ready
);
   import lj_pkg::*;

   front_state_type state_ff, state_in;

   logic [31:0] mag_ff [3];
   logic [31:0] dvd_ff [3];
   logic [31:0] rem_ff [3];
   logic [31:0] rem_in [3];
   logic [31:0] ax     [3];
   logic [30:0] width  [3];
   logic [32:0] diff   [3];
   logic [32:0] tmp    [3];
   logic [2:0]  wrap_on;
   logic [2:0]  near_ok;
   logic [4:0]  cnt_ff;
   logic [1:0]  sq_ff;
   logic [63:0] r2_ff;
   logic [61:0] csq_ff;
   logic        self_ff;
   logic        last_ff;
   logic [30:0] sq_op;
   logic [61:0] sq_prod;
   logic        in_cut;
   logic        accept;

   assign width[0] = cfg.box_width_x;
   assign width[1] = cfg.box_width_y;
   assign width[2] = cfg.box_width_z;

   assign diff[0] = {req_ref_x[31], req_ref_x} - {req_neighbor_x[31], req_neighbor_x};
   assign diff[1] = {req_ref_y[31], req_ref_y} - {req_neighbor_y[31], req_neighbor_y};
   assign diff[2] = {req_ref_z[31], req_ref_z} - {req_neighbor_z[31], req_neighbor_z};

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         wrap_on[i] = cfg.periodic_mask[i] && (width[i] != '0);
         tmp[i]     = {rem_ff[i], dvd_ff[i][31]};
         if (tmp[i] >= {2'b00, width[i]}) begin
            rem_in[i] = 32'(tmp[i] - {2'b00, width[i]});
         end else begin
            rem_in[i] = tmp[i][31:0];
         end
         // nearest image: round half away from zero on the remainder
         if (!wrap_on[i]) begin
            ax[i] = mag_ff[i];
         end else if ({rem_ff[i], 1'b0} >= {2'b00, width[i]}) begin
            ax[i] = {1'b0, width[i]} - rem_ff[i];
         end else begin
            ax[i] = rem_ff[i];
         end
         near_ok[i] = ax[i] <= {1'b0, cfg.cutoff_radius};
      end
      in_cut = &near_ok;
   end

   always_comb begin
      unique case (sq_ff)
         2'd0:    sq_op = ax[0][30:0];
         2'd1:    sq_op = ax[1][30:0];
         2'd2:    sq_op = ax[2][30:0];
         default: sq_op = cfg.cutoff_radius;
      endcase
      sq_prod = {31'd0, sq_op} * {31'd0, sq_op};
   end

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      job_valid = 1'b0;
      unique case (state_ff)
         F_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) state_in = F_DIV;
         end
         F_DIV: begin
            if (cnt_ff == 5'd31) state_in = F_SQ;
         end
         F_SQ: begin
            if (sq_ff == 2'd3) state_in = F_PUSH;
         end
         F_PUSH: begin
            job_valid = 1'b1;
            if (job_ready) state_in = F_IDLE;
         end
         default: state_in = F_IDLE;
      endcase
   end

   assign accept      = req_valid && req_ready;
   assign job.term_en = !self_ff && in_cut && (r2_ff <= {2'b00, csq_ff});
   assign job.r2      = r2_ff;
   assign job.last    = last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         for (int i = 0; i < 3; i++) begin
            mag_ff[i] <= diff[i][32] ? 32'(-diff[i]) : diff[i][31:0];
            dvd_ff[i] <= diff[i][32] ? 32'(-diff[i]) : diff[i][31:0];
            rem_ff[i] <= '0;
         end
         cnt_ff  <= '0;
         self_ff <= req_is_self;
         last_ff <= req_last_neighbor;
      end else if (state_ff == F_DIV) begin
         for (int i = 0; i < 3; i++) begin
            dvd_ff[i] <= {dvd_ff[i][30:0], 1'b0};
            rem_ff[i] <= rem_in[i];
         end
         cnt_ff <= cnt_ff + 5'd1;
         sq_ff  <= '0;
         r2_ff  <= '0;
      end else if (state_ff == F_SQ) begin
         if (sq_ff == 2'd3) begin
            csq_ff <= sq_prod;
         end else begin
            r2_ff <= r2_ff + {2'b00, sq_prod};
         end
         sq_ff <= sq_ff + 2'd1;
      end
   end

endmodule

// ===== rtl/lj_fifo.sv =====
// ----------------------------------------------------------------------------
// lj_fifo
// short job queue between the classifier and the energy unit
// ----------------------------------------------------------------------------
module lj_fifo (
   input  logic               clock,
   input  logic               reset,
   input  lj_pkg::lj_job_type wr_job,
   input  logic               wr_valid,
   output logic               wr_ready,
   output lj_pkg::lj_job_type rd_job,
   output logic               rd_valid,
   input  logic               rd_ready
);
   import lj_pkg::*;

   lj_job_type          mem_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0] wr_ptr_ff;
   logic [QUEUE_AW-1:0] rd_ptr_ff;
   logic [QUEUE_AW:0]   count_ff;
   logic                push;
   logic                pop;

   assign wr_ready = count_ff != (QUEUE_AW+1)'(QUEUE_DEPTH);
   assign rd_valid = count_ff != '0;
   assign rd_job   = mem_ff[rd_ptr_ff];
   assign push     = wr_valid && wr_ready;
   assign pop      = rd_valid && rd_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (pop)  rd_ptr_ff <= rd_ptr_ff + 1'b1;
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= wr_job;
   end

endmodule

// ===== rtl/lj_back.sv =====
// ----------------------------------------------------------------------------
// lj_back
// pair energy unit: serial divider, split 64x64 multiplier and saturating sum
// ----------------------------------------------------------------------------
module lj_back (
   input  logic                      clock,
   input  logic                      reset,
   input  lj_pkg::lj_cfg_type        cfg,
   input  lj_pkg::lj_job_type        job,
   input  logic                      job_valid,
   output logic                      job_ready,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic signed [47:0]        rsp_total_energy,
   output logic                      rsp_saturated
);
   import lj_pkg::*;

   localparam int DIV_W = 62 + FRAC_BITS;

   back_state_type state_ff, state_in;
   mul_op_type     op_ff;

   logic [63:0]       r2_ff;
   logic              last_ff;
   logic [DIV_W-1:0]  dvd_ff;
   logic [DIV_W-1:0]  quo_ff;
   logic [63:0]       rem_ff;
   logic [64:0]       div_tmp;
   logic              div_ge;
   logic [6:0]        cnt_ff;
   logic [63:0]       a_ff;
   logic [63:0]       b_ff;
   logic [1:0]        k_ff;
   logic [127:0]      acc_ff;
   logic [31:0]       a_part;
   logic [31:0]       b_part;
   logic [63:0]       pp;
   logic [127:0]      pp_sh;
   logic [63:0]       s2_ff;
   logic [63:0]       s6_ff;
   logic              neg_ff;
   logic [63:0]       mul_res;
   logic              mul_ovf;
   logic              s12_neg;
   logic [63:0]       s_mag;
   logic [61:0]       sig2;
   logic [SUM_W-1:0]  term_ff;
   logic              tflag_ff;
   logic [SUM_W-1:0]  term_mag;
   logic              term_cap;
   logic [SUM_W-1:0]  sum_ff;
   logic              seen_ff;
   logic [SUM_W:0]    sum_wide;
   logic [SUM_W-1:0]  sum_sat;
   logic              sum_ovf;
   logic              out_free;
   logic              rsp_valid_ff;
   logic [SUM_W-1:0]  rsp_energy_ff;
   logic              rsp_sat_ff;
   logic              take;
   logic              direct;

   assign sig2    = {31'd0, cfg.contact_size} * {31'd0, cfg.contact_size};
   assign div_tmp = {rem_ff, dvd_ff[DIV_W-1]};
   assign div_ge  = div_tmp >= {1'b0, r2_ff};

   assign a_part = k_ff[1] ? a_ff[63:32] : a_ff[31:0];
   assign b_part = k_ff[0] ? b_ff[63:32] : b_ff[31:0];
   assign pp     = {32'd0, a_part} * {32'd0, b_part};

   always_comb begin
      unique case (k_ff)
         2'd0:    pp_sh = {64'd0, pp};
         2'd3:    pp_sh = {pp, 64'd0};
         default: pp_sh = {32'd0, pp, 32'd0};
      endcase
   end

   assign mul_ovf  = acc_ff[127:64+FRAC_BITS] != '0;
   assign mul_res  = acc_ff[63+FRAC_BITS:FRAC_BITS];
   assign s12_neg  = mul_res < s6_ff;
   assign s_mag    = s12_neg ? s6_ff - mul_res : mul_res - s6_ff;
   assign term_cap = acc_ff[127:SUM_W-1+FRAC_BITS] != '0;
   assign term_mag = term_cap ? SUM_MAX : {1'b0, acc_ff[SUM_W-2+FRAC_BITS:FRAC_BITS]};

   assign sum_wide = {sum_ff[SUM_W-1], sum_ff} + {term_ff[SUM_W-1], term_ff};
   assign sum_ovf  = sum_wide[SUM_W] != sum_wide[SUM_W-1];
   assign sum_sat  = !sum_ovf ? sum_wide[SUM_W-1:0] : (sum_wide[SUM_W] ? SUM_MIN : SUM_MAX);
   assign out_free = !rsp_valid_ff || rsp_ready;

   // pairs with no term, or with zero separation, go straight to the sum
   assign direct = !job.term_en || (cfg.well_depth == '0) || (job.r2 == '0);

   always_comb begin
      state_in  = state_ff;
      job_ready = 1'b0;
      unique case (state_ff)
         B_IDLE: begin
            job_ready = 1'b1;
            if (job_valid) state_in = direct ? B_ACC : B_SIG;
         end
         B_SIG:  state_in = B_DIV;
         B_DIV: begin
            if (cnt_ff == 7'(DIV_W - 1)) state_in = B_DEND;
         end
         B_DEND: state_in = (quo_ff[DIV_W-1:64] != '0) ? B_ACC : B_MUL;
         B_MUL: begin
            if (k_ff == 2'd3) state_in = B_EVAL;
         end
         B_EVAL: begin
            if (op_ff == OP_TERM || (op_ff != OP_S12 && mul_ovf) ||
                (op_ff == OP_S12 && mul_ovf)) begin
               state_in = B_ACC;
            end else begin
               state_in = B_MUL;
            end
         end
         B_ACC: begin
            if (!last_ff || out_free) state_in = B_IDLE;
         end
         default: state_in = B_IDLE;
      endcase
   end

   assign take = job_valid && job_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         sum_ff       <= '0;
         seen_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == B_ACC && (!last_ff || out_free)) begin
            if (last_ff) begin
               sum_ff       <= '0;
               seen_ff      <= 1'b0;
               rsp_valid_ff <= 1'b1;
            end else begin
               sum_ff  <= sum_sat;
               seen_ff <= seen_ff || tflag_ff || sum_ovf;
               if (rsp_ready) rsp_valid_ff <= 1'b0;
            end
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         r2_ff   <= job.r2;
         last_ff <= job.last;
         if (!job.term_en || cfg.well_depth == '0) begin
            term_ff  <= '0;
            tflag_ff <= 1'b0;
         end else begin
            term_ff  <= SUM_MAX;
            tflag_ff <= 1'b1;
         end
      end
      unique case (state_ff)
         B_SIG: begin
            dvd_ff <= {sig2, {FRAC_BITS{1'b0}}};
            rem_ff <= '0;
            cnt_ff <= '0;
         end
         B_DIV: begin
            dvd_ff <= {dvd_ff[DIV_W-2:0], 1'b0};
            quo_ff <= {quo_ff[DIV_W-2:0], div_ge};
            rem_ff <= div_ge ? 64'(div_tmp - {1'b0, r2_ff}) : div_tmp[63:0];
            cnt_ff <= cnt_ff + 7'd1;
         end
         B_DEND: begin
            s2_ff  <= quo_ff[63:0];
            a_ff   <= quo_ff[63:0];
            b_ff   <= quo_ff[63:0];
            op_ff  <= OP_Q4;
            k_ff   <= '0;
            acc_ff <= '0;
         end
         B_MUL: begin
            acc_ff <= acc_ff + pp_sh;
            k_ff   <= k_ff + 2'd1;
         end
         B_EVAL: begin
            acc_ff <= '0;
            k_ff   <= '0;
            unique case (op_ff)
               OP_Q4: begin
                  a_ff  <= mul_res;
                  b_ff  <= s2_ff;
                  op_ff <= OP_S6;
               end
               OP_S6: begin
                  s6_ff <= mul_res;
                  a_ff  <= mul_res;
                  b_ff  <= mul_res;
                  op_ff <= OP_S12;
               end
               OP_S12: begin
                  neg_ff <= s12_neg;
                  a_ff   <= {31'd0, cfg.well_depth, 2'b00};
                  b_ff   <= s_mag;
                  op_ff  <= OP_TERM;
               end
               default: begin
                  term_ff  <= neg_ff ? SUM_W'(-term_mag) : term_mag;
                  tflag_ff <= term_cap;
               end
            endcase
         end
         default: begin
         end
      endcase
      if (state_ff == B_ACC && last_ff && out_free) begin
         rsp_energy_ff <= sum_sat;
         rsp_sat_ff    <= seen_ff || tflag_ff || sum_ovf;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_total_energy = rsp_energy_ff;
   assign rsp_saturated    = rsp_sat_ff;

endmodule

// ===== rtl/lennard_jones_energy_sum_top.sv =====
// ----------------------------------------------------------------------------
// lennard_jones_energy_sum_top
// lennard-jones 12-6 energy sum with minimum-image separation
// ----------------------------------------------------------------------------
// One neighbor per transfer on req_. The classifier works on a pair as one
// 32-step remainder per axis, run side by side, then four squares on one
// multiplier. The energy unit passes a skipped pair straight to the sum; a
// pair inside the cutoff goes through its 78-step serial divider and four
// 64x64 products built from 32x32 partial products.
// A two-entry queue sits between the two. On last_neighbor the signed Q32.16
// sum and its saturation flag appear on rsp_, and the sum is cleared.
// Configuration writes are taken at any time but belong to idle periods.
module lennard_jones_energy_sum_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write_enable,
   input  logic [2:0]         csr_index,
   input  logic [30:0]        csr_write_data,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [31:0] req_ref_x,
   input  logic signed [31:0] req_ref_y,
   input  logic signed [31:0] req_ref_z,
   input  logic signed [31:0] req_neighbor_x,
   input  logic signed [31:0] req_neighbor_y,
   input  logic signed [31:0] req_neighbor_z,
   input  logic               req_is_self,
   input  logic               req_last_neighbor,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [47:0] rsp_total_energy,
   output logic               rsp_saturated
);
   import lj_pkg::*;

   lj_cfg_type cfg_ff;
   lj_job_type front_job;
   lj_job_type back_job;
   logic       front_valid;
   logic       front_ready;
   logic       back_valid;
   logic       back_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.well_depth    <= '0;
         cfg_ff.contact_size  <= CFG_W'(1 << FRAC_BITS);
         cfg_ff.cutoff_radius <= '0;
         cfg_ff.box_width_x   <= CFG_W'(1 << FRAC_BITS);
         cfg_ff.box_width_y   <= CFG_W'(1 << FRAC_BITS);
         cfg_ff.box_width_z   <= CFG_W'(1 << FRAC_BITS);
         cfg_ff.periodic_mask <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_WELL_DEPTH:    cfg_ff.well_depth    <= csr_write_data;
            CSR_CONTACT_SIZE:  cfg_ff.contact_size  <= csr_write_data;
            CSR_CUTOFF_RADIUS: cfg_ff.cutoff_radius <= csr_write_data;
            CSR_BOX_WIDTH_X:   cfg_ff.box_width_x   <= csr_write_data;
            CSR_BOX_WIDTH_Y:   cfg_ff.box_width_y   <= csr_write_data;
            CSR_BOX_WIDTH_Z:   cfg_ff.box_width_z   <= csr_write_data;
            CSR_PERIODIC_MASK: cfg_ff.periodic_mask <= csr_write_data[2:0];
            default: begin
            end
         endcase
      end
   end

   lj_front u_front (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg_ff),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_ref_x         (req_ref_x),
      .req_ref_y         (req_ref_y),
      .req_ref_z         (req_ref_z),
      .req_neighbor_x    (req_neighbor_x),
      .req_neighbor_y    (req_neighbor_y),
      .req_neighbor_z    (req_neighbor_z),
      .req_is_self       (req_is_self),
      .req_last_neighbor (req_last_neighbor),
      .job               (front_job),
      .job_valid         (front_valid),
      .job_ready         (front_ready)
   );

   lj_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .wr_job   (front_job),
      .wr_valid (front_valid),
      .wr_ready (front_ready),
      .rd_job   (back_job),
      .rd_valid (back_valid),
      .rd_ready (back_ready)
   );

   lj_back u_back (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .job              (back_job),
      .job_valid        (back_valid),
      .job_ready        (back_ready),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_total_energy (rsp_total_energy),
      .rsp_saturated    (rsp_saturated)
   );

endmodule

// ===== rtl/lj_checker.sv =====
// ----------------------------------------------------------------------------
// lj_checker
// port-level checks of the energy accumulator, bound to the top level
// ----------------------------------------------------------------------------
module lj_checker (
   input logic               clock,
   input logic               reset,
   input logic               csr_write_enable,
   input logic [2:0]         csr_index,
   input logic [30:0]        csr_write_data,
   input logic               req_valid,
   input logic               req_ready,
   input logic signed [31:0] req_ref_x,
   input logic signed [31:0] req_ref_y,
   input logic signed [31:0] req_ref_z,
   input logic signed [31:0] req_neighbor_x,
   input logic signed [31:0] req_neighbor_y,
   input logic signed [31:0] req_neighbor_z,
   input logic               req_is_self,
   input logic               req_last_neighbor,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic signed [47:0] rsp_total_energy,
   input logic               rsp_saturated
);

   logic [2:0] pending_ff;
   logic       last_in;
   logic       rsp_out;

   assign last_in = req_valid && req_ready && req_last_neighbor;
   assign rsp_out = rsp_valid && rsp_ready;

   // result transfers still owed
   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else if (last_in && !rsp_out) begin
         pending_ff <= pending_ff + 3'd1;
      end else if (rsp_out && !last_in) begin
         pending_ff <= pending_ff - 3'd1;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_total_energy) &&
                                  $stable(rsp_saturated))
      else $error("result changed while stalled");

   a_rsp_owed: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pending_ff != 3'd0)
      else $error("result without a last neighbor");

   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input taken again before the pair was classified");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind lennard_jones_energy_sum_top lj_checker u_lj_checker (.*);
